// ===== hdl/bpa_pkg.sv =====
// Shared types and constants of the buddy page allocator.
// No dependencies; the interfaces and the allocator take this package in.
package bpa_pkg;

	localparam int CMD_W      = 1;
	localparam int ORDER_W    = 4;
	localparam int ZONE_W     = 2;
	localparam int PAGE_W     = 10;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_ORDER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_GROW   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NO_MEM    = 3'd1,
		STAT_BAD_ORDER = 3'd2,
		STAT_NOT_ALLOC = 3'd3,
		STAT_BAD_ADDR  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_A_SCAN,
		S_A_PICK,
		S_A_TAKE,
		S_A_HRD,
		S_A_HCHK,
		S_A_SPLIT,
		S_GROW,
		S_F_RD,
		S_F_CHK,
		S_F_LOOP,
		S_F_BCHK,
		S_F_MERGE,
		S_F_END,
		S_U0,
		S_U1,
		S_P0,
		S_P1,
		S_P2,
		S_FIN
	} state_t;

endpackage

// ===== hdl/bpa_req_if.sv =====
// Command channel of the buddy page allocator.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
	logic                           valid;
	logic                           ready;
	logic [bpa_pkg::CMD_W-1:0]      cmd;
	logic [bpa_pkg::ORDER_W-1:0]    order;
	logic [bpa_pkg::ZONE_W-1:0]     zone;
	logic [bpa_pkg::PAGE_W-1:0]     page_index;

	modport src (output valid, cmd, order, zone, page_index, input ready);
	modport snk (input valid, cmd, order, zone, page_index, output ready);
endinterface

// ===== hdl/bpa_rsp_if.sv =====
// Result channel of the buddy page allocator.
// Depends on bpa_pkg for field widths.
interface bpa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bpa_pkg::STATUS_W-1:0]   status;
	logic [bpa_pkg::ZONE_W-1:0]     zone_res;
	logic [bpa_pkg::PAGE_W-1:0]     page_index_res;

	modport src (output valid, status, zone_res, page_index_res, input ready);
	modport snk (input valid, status, zone_res, page_index_res, output ready);
endinterface

// ===== hdl/bpa_cfg_if.sv =====
// Register write channel of the buddy page allocator.
// Depends on bpa_pkg for field widths.
interface bpa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bpa_pkg::CFG_IDX_W-1:0]    index;
	logic [bpa_pkg::CFG_DATA_W-1:0]   data;

	modport src (output valid, index, data, input ready);
	modport snk (input valid, index, data, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/buddy_page_allocator.sv =====
// Buddy page allocator: one command at a time under a state-machine sequencer.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_cfg_if and bpa_ram.
//
// Each command runs on one sequencer that steps through four memories, each
// with one write port and one registered read port (page order and allocated
// bit, next link, previous link, list heads). An allocate scans the active
// zones, probes the free lists, unlinks the chosen block and splits it level
// by level; a free reads the page, merges level by level and ends with a
// push of the final block. A finished word waits in an output register
// while the next command is taken. After reset and after every register
// write the block clears its memories, one page a cycle, over all
// 2^ZW * 2^MAX_ORDER entries, and takes no command meanwhile.
module buddy_page_allocator #(
	parameter int MAX_ORDER = 10,
	parameter int NUM_ZONES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	bpa_req_if.snk     req,
	bpa_rsp_if.src     rsp,
	bpa_cfg_if.snk     cfg
);
	import bpa_pkg::*;

	localparam int PW  = MAX_ORDER;
	localparam int OW  = $clog2(MAX_ORDER + 1);
	localparam int ZW  = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
	localparam int AW  = $clog2(NUM_ZONES + 1);
	localparam int NW  = PW + 1;
	localparam int FW  = PW + 1;
	localparam int DW  = OW + 1;
	localparam int PAW = ZW + PW;
	localparam int HAW = ZW + OW;
	localparam int PD  = 1 << PAW;
	localparam int HD  = 1 << HAW;
	localparam int NZ2 = 1 << ZW;
	localparam int ZCW = ZONE_W + AW;
	localparam int CW  = PAGE_W + PW + 1;

	localparam logic [OW-1:0] MAXO    = OW'(MAX_ORDER);
	localparam logic [OW-1:0] TOP_RST = OW'((MAX_ORDER < 10) ? MAX_ORDER : 10);
	localparam logic [NW-1:0] NIL     = {1'b1, {PW{1'b0}}};

	state_t state_q, state_d, ret_q;

	logic [PAW-1:0]  clr_q;
	logic [OW-1:0]   top_q;
	logic            nogrow_q;
	logic [AW-1:0]   zact_q;
	logic [FW-1:0]   fp_q [NZ2];
	logic [OW-1:0]   ord_q, k_q;
	logic [ZW-1:0]   z_q, zscan_q, best_q;
	logic [PW-1:0]   p_q, lp_q, pp_q;
	logic [NW-1:0]   hd_q;
	logic            bvalid_q;
	logic [FW-1:0]   left_q;
	status_t         status_q;
	logic            out_vld_q;
	status_t         out_status_q;
	logic [ZONE_W-1:0] out_zone_q;
	logic [PAGE_W-1:0] out_page_q;

	logic             p_we, n_we, v_we, h_we;
	logic [PAW-1:0]   p_waddr, p_raddr, n_waddr, v_waddr, l_raddr;
	logic [HAW-1:0]   h_waddr, h_raddr;
	logic [DW-1:0]    p_wdata, p_rdata;
	logic [NW-1:0]    n_wdata, n_rdata, v_wdata, v_rdata, h_wdata, h_rdata;

	logic            req_acc, cfg_acc, clr_last, fin_load;
	logic [ZW-1:0]   fp_idx;
	logic [FW-1:0]   fp_sel, need, diff;
	logic            scan_hit, scan_last, can_grow, h_nil;
	logic            bad_order, bad_addr, merge_ok;
	logic [OW-1:0]   k_m1, cfg_top;
	logic [PW-1:0]   half, buddy;

	assign cfg.ready = (state_q == S_IDLE) || (state_q == S_CLR);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign clr_last  = (clr_q == PAW'(PD - 1));
	assign fin_load  = (state_q == S_FIN) && (!out_vld_q || rsp.ready);

	assign fp_idx    = (state_q == S_A_SCAN) ? zscan_q : z_q;
	assign fp_sel    = fp_q[fp_idx];
	assign need      = FW'(1) << ord_q;
	assign diff      = fp_sel - need;
	assign scan_hit  = (fp_sel >= need) && (!bvalid_q || (left_q > diff));
	assign scan_last = ((AW'(zscan_q) + AW'(1)) == zact_q);
	assign can_grow  = (zact_q < AW'(NUM_ZONES)) && !nogrow_q;
	assign h_nil     = h_rdata[PW];
	assign k_m1      = k_q - OW'(1);
	assign half      = lp_q | (PW'(1) << k_m1);
	assign buddy     = p_q ^ (PW'(1) << k_q);
	assign merge_ok  = !p_rdata[OW] && (p_rdata[OW-1:0] == k_q);
	assign bad_order = ({1'b0, req.order} > (ORDER_W + 1)'(top_q));
	assign bad_addr  = (ZCW'(req.zone) >= ZCW'(zact_q)) ||
	                   (CW'(req.page_index) >= (CW'(1) << top_q));
	assign cfg_top   = (cfg.data > CFG_DATA_W'(MAX_ORDER)) ? MAXO : OW'(cfg.data);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:     if (clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (req_acc) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = bad_order ? S_FIN : S_A_SCAN;
					end else begin
						state_d = bad_addr ? S_FIN : S_F_RD;
					end
				end
			end
			S_A_SCAN:  if (scan_last) state_d = S_A_PICK;
			S_A_PICK:  state_d = bvalid_q ? S_A_TAKE : S_GROW;
			S_A_TAKE:  state_d = S_A_HRD;
			S_A_HRD:   state_d = S_A_HCHK;
			S_A_HCHK: begin
				if (!h_nil) begin
					state_d = S_U0;
				end else if (k_q == top_q) begin
					state_d = S_GROW;
				end else begin
					state_d = S_A_HRD;
				end
			end
			S_A_SPLIT: state_d = (k_q > ord_q) ? S_P0 : S_FIN;
			S_GROW:    state_d = can_grow ? S_P0 : S_FIN;
			S_F_RD:    state_d = S_F_CHK;
			S_F_CHK:   state_d = p_rdata[OW] ? S_F_LOOP : S_FIN;
			S_F_LOOP:  state_d = (k_q < top_q) ? S_F_BCHK : S_F_END;
			S_F_BCHK:  state_d = merge_ok ? S_U0 : S_F_END;
			S_F_MERGE: state_d = S_F_LOOP;
			S_F_END:   state_d = S_P0;
			S_U0:      state_d = S_U1;
			S_U1:      state_d = ret_q;
			S_P0:      state_d = S_P1;
			S_P1:      state_d = S_P2;
			S_P2:      state_d = ret_q;
			S_FIN:     if (fin_load) state_d = S_IDLE;
			default:   state_d = S_CLR;
		endcase
		if (cfg_acc) begin
			state_d = S_CLR;
		end
	end

	// memory port control
	always_comb begin
		p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = {z_q, p_q};
		n_we = 1'b0; n_waddr = '0; n_wdata = '0;
		v_we = 1'b0; v_waddr = '0; v_wdata = '0;
		h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = {z_q, k_q};
		l_raddr = {z_q, lp_q};
		case (state_q)
			S_CLR: begin
				p_we = 1'b1; p_waddr = clr_q;
				p_wdata = (clr_q == '0) ? {1'b0, top_q} : '0;
				n_we = 1'b1; n_waddr = clr_q; n_wdata = NIL;
				v_we = 1'b1; v_waddr = clr_q; v_wdata = NIL;
				h_we = 1'b1; h_waddr = clr_q[HAW-1:0];
				h_wdata = (clr_q[HAW-1:0] == HAW'(top_q)) ? '0 : NIL;
			end
			S_GROW: begin
				p_we = can_grow; p_waddr = {ZW'(zact_q), {PW{1'b0}}};
				p_wdata = {1'b0, top_q};
			end
			S_A_SPLIT: begin
				p_we = 1'b1;
				if (k_q > ord_q) begin
					p_waddr = {z_q, half}; p_wdata = {1'b0, k_m1};
				end else begin
					p_waddr = {z_q, lp_q}; p_wdata = {1'b1, ord_q};
				end
			end
			S_F_LOOP:  p_raddr = {z_q, buddy};
			S_F_MERGE: begin
				p_we = 1'b1;
				p_waddr = (lp_q < p_q) ? {z_q, p_q} : {z_q, lp_q};
			end
			S_F_END: begin
				p_we = 1'b1; p_waddr = {z_q, p_q}; p_wdata = {1'b0, k_q};
			end
			S_U1: begin
				if (v_rdata[PW]) begin
					h_we = 1'b1; h_waddr = {z_q, k_q}; h_wdata = n_rdata;
				end else begin
					n_we = 1'b1; n_waddr = {z_q, v_rdata[PW-1:0]}; n_wdata = n_rdata;
				end
				if (!n_rdata[PW]) begin
					v_we = 1'b1; v_waddr = {z_q, n_rdata[PW-1:0]}; v_wdata = v_rdata;
				end
			end
			S_P1: begin
				n_we = 1'b1; n_waddr = {z_q, pp_q}; n_wdata = h_rdata;
				v_we = 1'b1; v_waddr = {z_q, pp_q}; v_wdata = NIL;
				h_we = 1'b1; h_waddr = {z_q, k_q}; h_wdata = {1'b0, pp_q};
			end
			S_P2: begin
				v_we = !hd_q[PW]; v_waddr = {z_q, hd_q[PW-1:0]}; v_wdata = {1'b0, pp_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			top_q     <= TOP_RST;
			nogrow_q  <= 1'b0;
			zact_q    <= AW'(1);
			for (int i = 0; i < NZ2; i++) begin
				fp_q[i] <= (i == 0) ? (FW'(1) << TOP_RST) : '0;
			end
			ret_q     <= S_IDLE;
			bvalid_q  <= 1'b0;
			status_q  <= STAT_OK;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					// the count wraps to zero at the last page
					clr_q <= cfg_acc ? '0 : clr_q + PAW'(1);
					if (clr_last) begin
						fp_q[0] <= FW'(1) << top_q;
						zact_q  <= AW'(1);
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						ord_q    <= OW'(req.order);
						z_q      <= ZW'(req.zone);
						p_q      <= PW'(req.page_index);
						zscan_q  <= '0;
						bvalid_q <= 1'b0;
						if (req.cmd == CMD_ALLOC) begin
							status_q <= bad_order ? STAT_BAD_ORDER : STAT_OK;
						end else begin
							status_q <= bad_addr ? STAT_BAD_ADDR : STAT_OK;
						end
					end
				end
				S_A_SCAN: begin
					if (scan_hit) begin
						best_q   <= zscan_q;
						left_q   <= diff;
						bvalid_q <= 1'b1;
					end
					zscan_q <= zscan_q + ZW'(1);
				end
				S_A_PICK:  z_q <= best_q;
				S_A_TAKE:  k_q <= ord_q;
				S_A_HCHK: begin
					if (!h_nil) begin
						lp_q       <= h_rdata[PW-1:0];
						fp_q[z_q]  <= fp_sel - need;
						ret_q      <= S_A_SPLIT;
					end else if (k_q != top_q) begin
						k_q <= k_q + OW'(1);
					end
				end
				S_GROW: begin
					if (can_grow) begin
						z_q                <= ZW'(zact_q);
						fp_q[ZW'(zact_q)]  <= FW'(1) << top_q;
						zact_q             <= zact_q + AW'(1);
						k_q                <= top_q;
						pp_q               <= '0;
						ret_q              <= S_A_TAKE;
					end else begin
						status_q <= STAT_NO_MEM;
					end
				end
				S_A_SPLIT: begin
					if (k_q > ord_q) begin
						k_q   <= k_m1;
						pp_q  <= half;
						ret_q <= S_A_SPLIT;
					end
				end
				S_F_CHK: begin
					if (!p_rdata[OW]) begin
						status_q <= STAT_NOT_ALLOC;
					end else begin
						k_q       <= p_rdata[OW-1:0];
						fp_q[z_q] <= fp_sel + (FW'(1) << p_rdata[OW-1:0]);
					end
				end
				S_F_LOOP:  lp_q  <= buddy;
				S_F_BCHK:  ret_q <= S_F_MERGE;
				S_F_MERGE: begin
					if (lp_q < p_q) begin
						p_q <= lp_q;
					end
					k_q <= k_q + OW'(1);
				end
				S_F_END: begin
					pp_q  <= p_q;
					ret_q <= S_FIN;
				end
				S_P1:      hd_q <= h_rdata;
				default: begin
				end
			endcase

			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (cfg_acc) begin
				case (cfg.index)
					CFG_TOP_ORDER: top_q    <= cfg_top;
					CFG_NO_GROW:   nogrow_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// result word; grant fields only on a successful allocate
	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_status_q <= status_q;
			if ((status_q == STAT_OK) && (ret_q != S_FIN)) begin
				out_zone_q <= ZONE_W'(z_q);
				out_page_q <= PAGE_W'(lp_q);
			end else begin
				out_zone_q <= '0;
				out_page_q <= '0;
			end
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.zone_res       = out_zone_q;
	assign rsp.page_index_res = out_page_q;

	bpa_ram #(.WIDTH(DW), .DEPTH(PD)) u_page_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	bpa_ram #(.WIDTH(NW), .DEPTH(PD)) u_next_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(l_raddr), .rdata(n_rdata)
	);

	bpa_ram #(.WIDTH(NW), .DEPTH(PD)) u_prev_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(l_raddr), .rdata(v_rdata)
	);

	bpa_ram #(.WIDTH(NW), .DEPTH(HD)) u_head_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

`ifndef ASSERT_OFF
	a_zones_active: assert property (@(posedge clk) disable iff (!arst_n)
		(zact_q != '0) && (zact_q <= AW'(NUM_ZONES)))
		else $error("active zone count out of range");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != STAT_OK) |->
			(rsp.zone_res == '0) && (rsp.page_index_res == '0))
		else $error("failed command carries a grant");

	a_zone0_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (fp_q[0] <= (FW'(1) << top_q)))
		else $error("zone 0 free count above zone size");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (state_q == S_CLR) && (clr_q == '0))
		else $error("register write did not restart clearing");
`endif
endmodule
